>>> src/rrt_pkg.sv
// Shared types, codes and helpers for the reassembly range tracker.
package rrt_pkg;

  localparam int POS_W  = 32;
  localparam int LEN_W  = 23;
  localparam int STAT_W = 3;
  localparam int ACT_W  = 2;
  localparam int BC_W   = 11;
  localparam int ADDR_W = 3;

  localparam logic [BC_W-1:0]   BC_LOW  = 11'd1;
  localparam logic [BC_W-1:0]   BC_HIGH = 11'd1024;
  localparam logic [ADDR_W-1:0] REG_BLOCK_COUNT = 3'd0;

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE   = 2'd0,
    ACT_APPEND  = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_NOP     = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_DUP     = 3'd1,
    ST_RANGE   = 3'd2,
    ST_FULL    = 3'd3,
    ST_NOSPACE = 3'd4,
    ST_RELBIG  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_SCAN, S_PLACE, S_MERGE, S_RSCAN, S_COMMIT, S_OUT
  } state_t;

  typedef struct packed {
    logic    load;
    logic    set_stat;
    status_t stat_val;
    logic    ptr_clr;
    logic    ptr_inc;
    logic    extend;
    logic    insert;
    logic    merge;
    logic    remove;
    logic    start_adv;
    logic    trim;
    logic    commit;
    logic    out_load;
  } rrt_cmd_t;

  typedef struct packed {
    action_t act;
    logic    wr_short;
    logic    out_range;
    logic    rel_big;
    logic    rel_exact;
    logic    scan_more;
    logic    dup;
    logic    touch;
    logic    full;
    logic    merge_more;
    logic    rs_end;
    logic    rs_hit;
  } rrt_sts_t;

  // a <= b in 32-bit sequence space
  function automatic logic seq_le(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
    logic [POS_W-1:0] d;
    d = a - b;
    return (d == '0) || d[POS_W-1];
  endfunction

endpackage

>>> src/rrt_if.sv
// Valid/ready channel interfaces for the input and result words.
interface rrt_in_if;
  import rrt_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] seg_pos;
  logic [22:0] seg_len;
  modport source (output valid, action, seg_pos, seg_len, input ready);
  modport sink   (input valid, action, seg_pos, seg_len, output ready);
endinterface

interface rrt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [22:0] readable_bytes;
  logic [22:0] writable_bytes;
  logic [31:0] window_start;
  logic [31:0] write_position;
  modport source (output valid, status, readable_bytes, writable_bytes, window_start,
                  write_position, input ready);
  modport sink   (input valid, status, readable_bytes, writable_bytes, window_start,
                  write_position, output ready);
endinterface

>>> src/rrt_ctrl.sv
// Sequencing state machine of the range tracker.
module rrt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rrt_pkg::rrt_sts_t sts,
  output rrt_pkg::rrt_cmd_t cmd
);
  import rrt_pkg::*;

  state_t state, state_next;

  // state register and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_CHECK;
      S_CHECK: begin
        unique case (sts.act) inside
          ACT_WRITE, ACT_APPEND: begin
            if ((sts.act == ACT_APPEND && sts.wr_short) || sts.out_range)
              state_next = S_COMMIT;
            else state_next = S_SCAN;
          end
          ACT_RELEASE: begin
            if (!sts.rel_big && sts.rel_exact) state_next = S_RSCAN;
            else state_next = S_COMMIT;
          end
          default: state_next = S_COMMIT;
        endcase
      end
      S_SCAN:  if (!sts.scan_more) state_next = S_PLACE;
      S_PLACE: begin
        if (sts.dup || (!sts.touch && sts.full)) state_next = S_COMMIT;
        else state_next = S_MERGE;
      end
      S_MERGE: if (!sts.merge_more) state_next = S_COMMIT;
      S_RSCAN: if (sts.rs_end || sts.rs_hit) state_next = S_COMMIT;
      S_COMMIT: state_next = S_OUT;
      S_OUT:   if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd = '0;
    cmd.stat_val = ST_OK;
    in_ready = (state == S_IDLE);
    unique case (state)
      S_IDLE: cmd.load = in_valid;
      S_CHECK: begin
        unique case (sts.act) inside
          ACT_WRITE, ACT_APPEND: begin
            cmd.ptr_clr = 1'b1;
            if (sts.act == ACT_APPEND && sts.wr_short) begin
              cmd.set_stat = 1'b1;
              cmd.stat_val = ST_NOSPACE;
            end else if (sts.out_range) begin
              cmd.set_stat = 1'b1;
              cmd.stat_val = ST_RANGE;
            end
          end
          ACT_RELEASE: begin
            cmd.ptr_clr = 1'b1;
            if (sts.rel_big) begin
              cmd.set_stat = 1'b1;
              cmd.stat_val = ST_RELBIG;
            end else if (!sts.rel_exact) begin
              cmd.trim      = 1'b1;
              cmd.start_adv = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_SCAN: cmd.ptr_inc = sts.scan_more;
      S_PLACE: begin
        if (sts.dup) begin
          cmd.set_stat = 1'b1;
          cmd.stat_val = ST_DUP;
        end else if (sts.touch) begin
          cmd.extend = 1'b1;
        end else if (sts.full) begin
          cmd.set_stat = 1'b1;
          cmd.stat_val = ST_FULL;
        end else begin
          cmd.insert = 1'b1;
        end
      end
      S_MERGE: cmd.merge = sts.merge_more;
      S_RSCAN: begin
        if (sts.rs_end) begin
          cmd.start_adv = 1'b1;
        end else if (sts.rs_hit) begin
          cmd.remove    = 1'b1;
          cmd.start_adv = 1'b1;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_COMMIT: cmd.commit = 1'b1;
      S_OUT: cmd.out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

endmodule

>>> src/rrt_dp.sv
// Range table, window positions and result register of the range tracker.
module rrt_dp #(
  parameter int BLOCK_BYTES = 4096,
  parameter int MAX_RANGES  = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  rrt_pkg::rrt_cmd_t         cmd,
  output rrt_pkg::rrt_sts_t         sts,
  input  logic [rrt_pkg::BC_W-1:0]  block_count,
  input  logic [rrt_pkg::ACT_W-1:0] in_action,
  input  logic [rrt_pkg::POS_W-1:0] in_pos,
  input  logic [rrt_pkg::LEN_W-1:0] in_len,
  output logic [rrt_pkg::STAT_W-1:0] out_status,
  output logic [rrt_pkg::LEN_W-1:0] out_readable,
  output logic [rrt_pkg::LEN_W-1:0] out_writable,
  output logic [rrt_pkg::POS_W-1:0] out_start,
  output logic [rrt_pkg::POS_W-1:0] out_append
);
  import rrt_pkg::*;

  localparam int BLK_W = $clog2(BLOCK_BYTES);
  localparam int SEL_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int IDX_W = $clog2(MAX_RANGES + 1);
  localparam int WIN_W = BC_W + BLK_W;

  action_t            act_q;
  logic [POS_W-1:0]   pos_q;
  logic [LEN_W-1:0]   len_q;
  status_t            stat_q;
  logic [POS_W-1:0]   start_q;
  logic [POS_W-1:0]   app_q;
  logic [POS_W-1:0]   starts [MAX_RANGES];
  logic [POS_W-1:0]   ends   [MAX_RANGES];
  logic [IDX_W-1:0]   count;
  logic [IDX_W-1:0]   ptr;

  logic [BC_W-1:0]    bc_eff;
  logic [WIN_W-1:0]   win;
  logic [POS_W-1:0]   win32, len32, seg_p, seg_e, d_app, writable32, readable32;
  logic [SEL_W-1:0]   ptr_sel, prev_sel, nxt_sel, rm_sel;
  logic [IDX_W:0]     ptr_p1;

  // window size from the block count and the start offset
  always_comb begin
    if (block_count < BC_LOW) bc_eff = BC_LOW;
    else if (block_count > BC_HIGH) bc_eff = BC_HIGH;
    else bc_eff = block_count;
    win   = {bc_eff, {BLK_W{1'b0}}} - WIN_W'(start_q[BLK_W-1:0]);
    win32 = POS_W'(win);
  end

  // segment bounds and window figures
  assign len32  = POS_W'(len_q);
  assign seg_p  = (act_q == ACT_APPEND) ? app_q : pos_q;
  assign seg_e  = seg_p + len32;
  assign d_app  = app_q - start_q;
  assign writable32 = (d_app > win32) ? '0 : win32 - d_app;
  assign readable32 = (count != '0 && starts[0] == start_q) ? ends[0] - starts[0] : '0;

  assign ptr_sel  = ptr[SEL_W-1:0];
  assign prev_sel = SEL_W'(ptr - 1'b1);
  assign ptr_p1   = {1'b0, ptr} + 1'b1;
  assign nxt_sel  = ptr_p1[SEL_W-1:0];
  assign rm_sel   = cmd.merge ? nxt_sel : ptr_sel;

  // status to the controller
  always_comb begin
    sts.act        = act_q;
    sts.wr_short   = writable32 < len32;
    sts.out_range  = (len32 > win32) || ((seg_p - start_q) > win32)
                     || ((seg_e - start_q) > win32);
    sts.rel_big    = len32 > readable32;
    sts.rel_exact  = len32 == readable32;
    sts.scan_more  = (ptr < count) && seq_le(starts[ptr_sel], seg_p);
    sts.dup        = (ptr != '0) && seq_le(seg_e, ends[prev_sel]);
    sts.touch      = (ptr != '0) && seq_le(seg_p, ends[prev_sel]);
    sts.full       = count >= IDX_W'(MAX_RANGES);
    sts.merge_more = (ptr_p1 < {1'b0, count}) && seq_le(starts[nxt_sel], ends[ptr_sel]);
    sts.rs_end     = ptr == count;
    sts.rs_hit     = starts[ptr_sel] == start_q;
  end

  // range table: shifts for insert and remove, extend, trim and merge
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RANGES; i++) begin
      if (cmd.remove || cmd.merge) begin
        if (i >= int'(rm_sel) && i < MAX_RANGES - 1) begin
          starts[i] <= starts[(i < MAX_RANGES - 1) ? i + 1 : i];
          ends[i]   <= ends[(i < MAX_RANGES - 1) ? i + 1 : i];
        end
      end else if (cmd.insert) begin
        if (i > int'(ptr_sel)) begin
          starts[i] <= starts[(i > 0) ? i - 1 : i];
          ends[i]   <= ends[(i > 0) ? i - 1 : i];
        end else if (i == int'(ptr_sel)) begin
          starts[i] <= seg_p;
          ends[i]   <= seg_e;
        end
      end
    end
    if (cmd.extend) ends[prev_sel] <= seg_e;
    if (cmd.merge && seq_le(ends[ptr_sel], ends[nxt_sel])) ends[ptr_sel] <= ends[nxt_sel];
    if (cmd.trim) starts[0] <= start_q + len32;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      ptr     <= '0;
      start_q <= '0;
      app_q   <= '0;
      stat_q  <= ST_OK;
    end else begin
      if (cmd.insert) count <= count + 1'b1;
      else if (cmd.remove || cmd.merge) count <= count - 1'b1;
      if (cmd.ptr_clr) ptr <= '0;
      else if (cmd.ptr_inc) ptr <= ptr + 1'b1;
      else if (cmd.extend) ptr <= ptr - 1'b1;
      if (cmd.load) stat_q <= ST_OK;
      else if (cmd.set_stat) stat_q <= cmd.stat_val;
      if (cmd.start_adv) start_q <= start_q + len32;
      if (cmd.commit && act_q == ACT_APPEND && (stat_q == ST_OK || stat_q == ST_DUP))
        app_q <= app_q + len32;
    end
  end

  // input word and result word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q <= action_t'(in_action);
      pos_q <= in_pos;
      len_q <= in_len;
    end
    if (cmd.out_load) begin
      out_status   <= stat_q;
      out_readable <= (|readable32[POS_W-1:LEN_W]) ? '1 : readable32[LEN_W-1:0];
      out_writable <= (|writable32[POS_W-1:LEN_W]) ? '1 : writable32[LEN_W-1:0];
      out_start    <= start_q;
      out_append   <= app_q;
    end
  end

endmodule

>>> src/reassembly_range_tracker.sv
// Reassembly range tracker: records which sequence ranges of a receive window hold
// data (up to MAX_RANGES sorted ranges; BLOCK_BYTES must be a power of two) and
// reports status, readable and writable bytes per word. One word is handled at a
// time: a write or append first passes the window check, then scans the stored
// ranges ahead of the segment, places the segment and merges the ranges that it
// reaches; a duplicate, or a segment that touches no range while the table is
// full, skips the merge pass, and a word refused at the window check skips the
// scan as well. A release that empties the front range looks up that range in the
// table before it commits. The range table scan and merge in the datapath set
// how long a word takes; a result held by the sink adds its wait.
// The result register frees the next input as soon as the result is loaded.
module reassembly_range_tracker #(
  parameter int BLOCK_BYTES = 4096,
  parameter int MAX_RANGES  = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  rrt_in_if.sink                     in_ch,
  rrt_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rrt_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import rrt_pkg::*;

  logic [BC_W-1:0] block_count;
  rrt_cmd_t        cmd;
  rrt_sts_t        sts;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == REG_BLOCK_COUNT) ? 32'(block_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= BC_LOW;
    end else if (psel && penable && pwrite && pready && paddr == REG_BLOCK_COUNT) begin
      block_count <= pwdata[BC_W-1:0];
    end
  end

  rrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rrt_dp #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .MAX_RANGES  (MAX_RANGES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .block_count  (block_count),
    .in_action    (in_ch.action),
    .in_pos       (in_ch.seg_pos),
    .in_len       (in_ch.seg_len),
    .out_status   (out_ch.status),
    .out_readable (out_ch.readable_bytes),
    .out_writable (out_ch.writable_bytes),
    .out_start    (out_ch.window_start),
    .out_append   (out_ch.write_position)
  );

endmodule
